[hdl/rmq_pkg.sv]
// rmq_pkg: shared constants, types and step functions for the matrix to quaternion pipeline
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int M_W       = 16;
  localparam int RAD_W     = M_W + 3;
  localparam int THR_W     = 15;
  localparam int X_W       = 30;
  localparam int ROOT_W    = X_W / 2;
  localparam int SQ_N      = ROOT_W;
  localparam int CMB_W     = M_W + 1;
  localparam int DEN_W     = ROOT_W + 2;
  localparam int QB        = 16;
  localparam int NUM_W     = DEN_W + QB - 1;
  localparam int DV_N      = QB;

  localparam logic [1:0] PIV_W = 2'd0;
  localparam logic [1:0] PIV_X = 2'd1;
  localparam logic [1:0] PIV_Y = 2'd2;
  localparam logic [1:0] PIV_Z = 2'd3;

  typedef struct packed {
    logic [X_W-1:0] rem;
    logic [X_W-1:0] res;
  } sqrt_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QB-1:0]    quo;
  } div_t;

  function automatic sqrt_t sqrt_step(sqrt_t s, int step);
    sqrt_t          o;
    logic [X_W-1:0] bitv;
    logic [X_W-1:0] trial;
    bitv  = X_W'(1) << (X_W - 2 - 2 * step);
    trial = s.res + bitv;
    if (s.rem >= trial) begin
      o.rem = s.rem - trial;
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.rem = s.rem;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t s, logic [DEN_W-1:0] den, int j);
    div_t             o;
    logic [NUM_W-1:0] trial;
    trial = NUM_W'(den) << j;
    o     = s;
    if (s.rem >= trial) begin
      o.rem    = s.rem - trial;
      o.quo[j] = 1'b1;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[hdl/rotation_matrix_to_quaternion.sv]
// rotation_matrix_to_quaternion: pipelined rotation matrix to unit quaternion converter
`timescale 1ns / 1ps
`default_nettype none

// Converts a Q1.14 rotation matrix to a Q1.14 quaternion by Shepperd's method. One matrix
// is taken per cycle while the output side keeps up. The pipeline runs through the square
// roots (one root bit per stage, 15 stages, all four candidate pivots in parallel), a pivot
// select register, a dividend set-up register and the three quotients (one quotient bit
// per stage, 16 stages). The whole pipeline holds when a result waits at the output.
// pivot_threshold is to be written only while no transaction is in flight.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic signed [M_W-1:0]   m00_i,
  input  wire logic signed [M_W-1:0]   m01_i,
  input  wire logic signed [M_W-1:0]   m02_i,
  input  wire logic signed [M_W-1:0]   m10_i,
  input  wire logic signed [M_W-1:0]   m11_i,
  input  wire logic signed [M_W-1:0]   m12_i,
  input  wire logic signed [M_W-1:0]   m20_i,
  input  wire logic signed [M_W-1:0]   m21_i,
  input  wire logic signed [M_W-1:0]   m22_i,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [THR_W-1:0]        pivot_threshold_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic signed [M_W-1:0]        quat_w_o,
  output logic signed [M_W-1:0]        quat_x_o,
  output logic signed [M_W-1:0]        quat_y_o,
  output logic signed [M_W-1:0]        quat_z_o,
  output logic [1:0]                   pivot_used_o,
  output logic                         saturated_o
);

  logic              adv;
  logic [THR_W-1:0]  thr_q;

  logic                    sv_q  [SQ_N+1];
  sqrt_t                   sq_q  [SQ_N+1][4];
  logic signed [CMB_W-1:0] cmb_q [SQ_N+1][6];

  logic signed [RAD_W-1:0] rad   [4];
  logic [X_W-1:0]          rad_x [4];
  logic signed [CMB_W-1:0] cmb_d [6];

  logic                    sel_v_q;
  logic [1:0]              sel_k_q;
  logic [ROOT_W-1:0]       sel_p_q;
  logic signed [CMB_W-1:0] sel_d_q [3];
  logic [1:0]              sel_k_d;
  logic [ROOT_W-1:0]       sel_p_d;
  logic signed [CMB_W-1:0] sel_d_d [3];
  logic [ROOT_W-1:0]       root [4];

  logic              dv_v_q   [DV_N+1];
  div_t              dv_q     [DV_N+1][3];
  logic [DEN_W-1:0]  dv_den_q [DV_N+1];
  logic [1:0]        dv_k_q   [DV_N+1];
  logic [ROOT_W-1:0] dv_p_q   [DV_N+1];
  logic [2:0]        dv_neg_q [DV_N+1];

  logic                    out_v_q;
  logic signed [M_W-1:0]   comp_q [4];
  logic [1:0]              out_k_q;
  logic                    out_sat_q;
  logic signed [M_W-1:0]   comp_d [4];
  logic                    out_sat_d;

  assign adv         = !out_v_q || out_ready_i;
  assign in_ready_o  = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i) begin
      thr_q <= pivot_threshold_i;
    end
  end

  // trace combinations and element sums and differences
  always_comb begin
    rad[0] = RAD_W'(ONE) + RAD_W'(m00_i) + RAD_W'(m11_i) + RAD_W'(m22_i);
    rad[1] = RAD_W'(ONE) + RAD_W'(m00_i) - RAD_W'(m11_i) - RAD_W'(m22_i);
    rad[2] = RAD_W'(ONE) - RAD_W'(m00_i) + RAD_W'(m11_i) - RAD_W'(m22_i);
    rad[3] = RAD_W'(ONE) - RAD_W'(m00_i) - RAD_W'(m11_i) + RAD_W'(m22_i);
    for (int n = 0; n < 4; n++) begin
      rad_x[n] = (rad[n] <= 0) ? '0 : (X_W'(rad[n]) << (FRAC_BITS - 2));
    end
    cmb_d[0] = CMB_W'(m21_i) - CMB_W'(m12_i);
    cmb_d[1] = CMB_W'(m02_i) - CMB_W'(m20_i);
    cmb_d[2] = CMB_W'(m10_i) - CMB_W'(m01_i);
    cmb_d[3] = CMB_W'(m10_i) + CMB_W'(m01_i);
    cmb_d[4] = CMB_W'(m20_i) + CMB_W'(m02_i);
    cmb_d[5] = CMB_W'(m21_i) + CMB_W'(m12_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      sv_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int n = 0; n < 4; n++) begin
        sq_q[0][n].rem <= rad_x[n];
        sq_q[0][n].res <= '0;
      end
      for (int n = 0; n < 6; n++) begin
        cmb_q[0][n] <= cmb_d[n];
      end
    end
  end

  // square root stages, one root bit each
  for (genvar i = 1; i <= SQ_N; i++) begin : g_sqrt
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[i] <= 1'b0;
      end else if (adv) begin
        sv_q[i] <= sv_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int n = 0; n < 4; n++) begin
          sq_q[i][n] <= sqrt_step(sq_q[i-1][n], i - 1);
        end
        for (int n = 0; n < 6; n++) begin
          cmb_q[i][n] <= cmb_q[i-1][n];
        end
      end
    end
  end

  // pivot selection
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      root[n] = sq_q[SQ_N][n].res[ROOT_W-1:0];
    end
    if (root[0] > thr_q) begin
      sel_k_d    = PIV_W;
      sel_p_d    = root[0];
      sel_d_d[0] = cmb_q[SQ_N][0];
      sel_d_d[1] = cmb_q[SQ_N][1];
      sel_d_d[2] = cmb_q[SQ_N][2];
    end else if (root[1] > thr_q) begin
      sel_k_d    = PIV_X;
      sel_p_d    = root[1];
      sel_d_d[0] = cmb_q[SQ_N][0];
      sel_d_d[1] = cmb_q[SQ_N][3];
      sel_d_d[2] = cmb_q[SQ_N][4];
    end else if (root[2] > thr_q) begin
      sel_k_d    = PIV_Y;
      sel_p_d    = root[2];
      sel_d_d[0] = cmb_q[SQ_N][1];
      sel_d_d[1] = cmb_q[SQ_N][3];
      sel_d_d[2] = cmb_q[SQ_N][5];
    end else begin
      sel_k_d    = PIV_Z;
      sel_p_d    = root[3];
      sel_d_d[0] = cmb_q[SQ_N][2];
      sel_d_d[1] = cmb_q[SQ_N][4];
      sel_d_d[2] = cmb_q[SQ_N][5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_v_q <= 1'b0;
    end else if (adv) begin
      sel_v_q <= sv_q[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sel_k_q <= sel_k_d;
      sel_p_q <= sel_p_d;
      for (int n = 0; n < 3; n++) begin
        sel_d_q[n] <= sel_d_d[n];
      end
    end
  end

  // dividend set-up, rounding half of the divisor added in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= sel_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [CMB_W-1:0] mag;
    if (adv) begin
      for (int n = 0; n < 3; n++) begin
        mag = sel_d_q[n][CMB_W-1] ? CMB_W'(-sel_d_q[n]) : CMB_W'(sel_d_q[n]);
        dv_q[0][n].rem <= (NUM_W'(mag) << FRAC_BITS) + NUM_W'({sel_p_q, 1'b0});
        dv_q[0][n].quo <= '0;
        dv_neg_q[0][n] <= sel_d_q[n][CMB_W-1];
      end
      dv_den_q[0] <= {sel_p_q, 2'b00};
      dv_k_q[0]   <= sel_k_q;
      dv_p_q[0]   <= sel_p_q;
    end
  end

  // division stages, one quotient bit each, top bit flags overflow
  for (genvar i = 1; i <= DV_N; i++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[i] <= 1'b0;
      end else if (adv) begin
        dv_v_q[i] <= dv_v_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int n = 0; n < 3; n++) begin
          dv_q[i][n] <= div_step(dv_q[i-1][n], dv_den_q[i-1], DV_N - i);
        end
        dv_den_q[i] <= dv_den_q[i-1];
        dv_k_q[i]   <= dv_k_q[i-1];
        dv_p_q[i]   <= dv_p_q[i-1];
        dv_neg_q[i] <= dv_neg_q[i-1];
      end
    end
  end

  // assembly and clamping
  always_comb begin
    logic signed [M_W-1:0] qv [3];
    logic                  psat;
    logic signed [M_W-1:0] pv;
    int                    j;
    out_sat_d = 1'b0;
    psat      = dv_p_q[DV_N] > ROOT_W'(ONE);
    pv        = psat ? M_W'(ONE) : M_W'(dv_p_q[DV_N]);
    for (int n = 0; n < 3; n++) begin
      if (dv_p_q[DV_N] == '0) begin
        qv[n] = '0;
      end else if (dv_q[DV_N][n].quo[QB-1] || dv_q[DV_N][n].quo > QB'(ONE)) begin
        out_sat_d = 1'b1;
        qv[n]     = dv_neg_q[DV_N][n] ? -M_W'(ONE) : M_W'(ONE);
      end else begin
        qv[n] = dv_neg_q[DV_N][n] ? -M_W'(dv_q[DV_N][n].quo) : M_W'(dv_q[DV_N][n].quo);
      end
    end
    out_sat_d = out_sat_d || psat;
    j = 0;
    for (int n = 0; n < 4; n++) begin
      if (2'(n) == dv_k_q[DV_N]) begin
        comp_d[n] = pv;
      end else begin
        comp_d[n] = qv[j];
        j         = j + 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v_q[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int n = 0; n < 4; n++) begin
        comp_q[n] <= comp_d[n];
      end
      out_k_q   <= dv_k_q[DV_N];
      out_sat_q <= out_sat_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign quat_w_o     = comp_q[0];
  assign quat_x_o     = comp_q[1];
  assign quat_y_o     = comp_q[2];
  assign quat_z_o     = comp_q[3];
  assign pivot_used_o = out_k_q;
  assign saturated_o  = out_sat_q;

endmodule

`default_nettype wire

[hdl/rmq_checker.sv]
// rmq_checker: port-level assertions for the matrix to quaternion converter, and its bind
`timescale 1ns / 1ps
`default_nettype none

module rmq_checker
  import rmq_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic signed [M_W-1:0] quat_w_o,
  input wire logic signed [M_W-1:0] quat_x_o,
  input wire logic signed [M_W-1:0] quat_y_o,
  input wire logic signed [M_W-1:0] quat_z_o,
  input wire logic [1:0]            pivot_used_o,
  input wire logic                  saturated_o
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quat_w_o) && $stable(quat_x_o)
      && $stable(quat_y_o) && $stable(quat_z_o) && $stable(pivot_used_o)
      && $stable(saturated_o))
    else $error("result changed while stalled");

  // empty output stage never blocks input
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // components stay within unit range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o <= M_W'(ONE) && quat_w_o >= -M_W'(ONE)
      && quat_x_o <= M_W'(ONE) && quat_x_o >= -M_W'(ONE)
      && quat_y_o <= M_W'(ONE) && quat_y_o >= -M_W'(ONE)
      && quat_z_o <= M_W'(ONE) && quat_z_o >= -M_W'(ONE))
    else $error("component out of range");

  // a scalar pivot is strictly positive
  a_w_pivot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pivot_used_o == PIV_W |-> quat_w_o > 0)
    else $error("scalar pivot not positive");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .quat_w_o     (quat_w_o),
  .quat_x_o     (quat_x_o),
  .quat_y_o     (quat_y_o),
  .quat_z_o     (quat_z_o),
  .pivot_used_o (pivot_used_o),
  .saturated_o  (saturated_o)
);

`default_nettype wire

[verif/tb_top.sv]
// tb_top: self-checking testbench for the rotation matrix to quaternion converter
`timescale 1ns / 1ps

module tb_top;
  import rmq_pkg::*;

  typedef struct {
    logic signed [M_W-1:0] m [9];
  } matrix_t;

  typedef struct {
    logic signed [M_W-1:0] w, x, y, z;
    logic [1:0]            piv;
    logic                  sat;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic signed [M_W-1:0] m_drv [9];
  logic cfg_valid = 1'b0, cfg_ready;
  logic [THR_W-1:0] thr_drv = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [M_W-1:0] qw, qx, qy, qz;
  logic [1:0] piv;
  logic sat;

  matrix_t pending_matrices [$];
  quat_t   expected_quats [$];
  logic [THR_W-1:0] cur_threshold = '0;
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  hold_in = 1'b0;
  int  in_gap = 0, out_gap = 0;

  initial for (int i = 0; i < 9; i++) m_drv[i] = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rotation_matrix_to_quaternion dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .m00_i(m_drv[0]), .m01_i(m_drv[1]), .m02_i(m_drv[2]),
    .m10_i(m_drv[3]), .m11_i(m_drv[4]), .m12_i(m_drv[5]),
    .m20_i(m_drv[6]), .m21_i(m_drv[7]), .m22_i(m_drv[8]),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .pivot_threshold_i(thr_drv),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .quat_w_o(qw), .quat_x_o(qx), .quat_y_o(qy), .quat_z_o(qz),
    .pivot_used_o(piv), .saturated_o(sat)
  );

  function automatic longint half_root(longint r);
    longint unsigned v, res, b;
    if (r <= 0) return 0;
    v = longint'(r) << (FRAC_BITS - 2);
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint quarter_quot(longint d, longint p);
    longint unsigned mag, den, q;
    if (p <= 0) return 0;
    mag = longint'(d < 0 ? -d : d) << FRAC_BITS;
    den = p * 4;
    q = (mag + den / 2) / den;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [M_W-1:0] clamp_part(longint v, ref logic s);
    longint hi, lo;
    hi = ONE < 32767 ? ONE : 32767;
    lo = -ONE > -32768 ? -ONE : -32768;
    if (v > hi) begin s = 1'b1; return M_W'(hi); end
    if (v < lo) begin s = 1'b1; return M_W'(lo); end
    return M_W'(v);
  endfunction

  function automatic quat_t predict_quat(matrix_t a, logic [THR_W-1:0] thr);
    longint m [9];
    longint q [4];
    longint p, t;
    int k;
    logic s;
    quat_t r;
    for (int i = 0; i < 9; i++) m[i] = a.m[i];
    t = thr;
    q = '{0, 0, 0, 0};
    s = 1'b0;
    if ((p = half_root(ONE + m[0] + m[4] + m[8])) > t) begin
      k = PIV_W;
      q[1] = quarter_quot(m[7] - m[5], p);
      q[2] = quarter_quot(m[2] - m[6], p);
      q[3] = quarter_quot(m[3] - m[1], p);
    end else if ((p = half_root(ONE + m[0] - m[4] - m[8])) > t) begin
      k = PIV_X;
      q[0] = quarter_quot(m[7] - m[5], p);
      q[2] = quarter_quot(m[3] + m[1], p);
      q[3] = quarter_quot(m[6] + m[2], p);
    end else if ((p = half_root(ONE - m[0] + m[4] - m[8])) > t) begin
      k = PIV_Y;
      q[0] = quarter_quot(m[2] - m[6], p);
      q[1] = quarter_quot(m[1] + m[3], p);
      q[3] = quarter_quot(m[7] + m[5], p);
    end else begin
      p = half_root(ONE - m[0] - m[4] + m[8]);
      k = PIV_Z;
      q[0] = quarter_quot(m[3] - m[1], p);
      q[1] = quarter_quot(m[6] + m[2], p);
      q[2] = quarter_quot(m[7] + m[5], p);
    end
    q[k] = p;
    r.w = clamp_part(q[0], s);
    r.x = clamp_part(q[1], s);
    r.y = clamp_part(q[2], s);
    r.z = clamp_part(q[3], s);
    r.piv = 2'(k);
    r.sat = s;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (in_valid && in_ready) begin
      expected_quats.push_back(predict_quat(pending_matrices.pop_front(), cur_threshold));
    end
    if (!(in_valid && !in_ready)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && ($urandom_range(0, 9) == 0)) begin
        in_gap <= $urandom_range(1, 14);
        in_valid <= 1'b0;
      end else if (!hold_in && pending_matrices.size() > 0) begin
        in_valid <= 1'b1;
        for (int i = 0; i < 9; i++) m_drv[i] <= pending_matrices[0].m[i];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    quat_t e;
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d", $time, qw, qx, qy, qz);
        errors <= errors + 1;
      end else begin
        e = expected_quats.pop_front();
        if ({qw, qx, qy, qz, piv, sat} !== {e.w, e.x, e.y, e.z, e.piv, e.sat}) begin
          $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d piv=%0d sat=%0b",
                   $time, e.w, e.x, e.y, e.z, e.piv, e.sat);
          $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d piv=%0d sat=%0b",
                   $time, qw, qx, qy, qz, piv, sat);
          errors <= errors + 1;
        end
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && ($urandom_range(0, 9) == 0)) begin
      out_gap <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic matrix_t make_matrix(int a0, a1, a2, a3, a4, a5, a6, a7, a8);
    matrix_t r;
    r.m = '{M_W'(a0), M_W'(a1), M_W'(a2), M_W'(a3), M_W'(a4), M_W'(a5),
            M_W'(a6), M_W'(a7), M_W'(a8)};
    return r;
  endfunction

  // random rotation-like matrix: mostly near a pivot-dominated shape, some raw noise
  function automatic matrix_t rand_matrix();
    matrix_t r;
    int sel, dg;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      if (sel == 0) r.m[i] = M_W'($urandom);
      else if (sel == 1) r.m[i] = M_W'($urandom_range(0, 32768)) - 16'sd16384;
      else r.m[i] = M_W'($urandom_range(0, 8000)) - 16'sd4000;
    end
    if (sel >= 2) begin
      dg = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++)
        r.m[4 * i] = M_W'((dg == 0 || dg == i + 1) ? $urandom_range(8000, 16384)
                                                    : -$urandom_range(8000, 16384));
    end
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_matrices.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    thr_drv <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cur_threshold = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int n);
    for (int i = 0; i < n; i++) pending_matrices.push_back(rand_matrix());
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed
    pending_matrices.push_back(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    pending_matrices.push_back(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    pending_matrices.push_back(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    pending_matrices.push_back(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    pending_matrices.push_back(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    pending_matrices.push_back(make_matrix(-32768, 32767, -32768, 32767, -32768, 32767,
                                           -32768, 32767, -32768));
    pending_matrices.push_back(make_matrix(32767, -32768, 32767, -32768, 32767, -32768,
                                           32767, -32768, 32767));
    pending_matrices.push_back(make_matrix(-5460, 16384, -16384, -16384, -5461, 16384,
                                           16384, -16384, -5461));
    pending_matrices.push_back(make_matrix(-16000, 32767, 32767, -32768, -16000, 32767,
                                           -32768, -32768, 16000));
    pending_matrices.push_back(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    wait_drained();
    // sender holds off while a batch of matrices queues up, then sends it
    hold_in = 1'b1;
    for (int i = 0; i < 20; i++) pending_matrices.push_back(rand_matrix());
    repeat (30) @(posedge clk);
    hold_in = 1'b0;
    wait_drained();
    write_threshold(15'd16384);
    pending_matrices.push_back(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    pending_matrices.push_back(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    run_phase(200);
    write_threshold(15'h7fff);
    run_phase(150);
    write_threshold(15'd4000);
    run_phase(300);
    write_threshold(15'd9000);
    run_phase(300);
    write_threshold(15'd0);
    run_phase(300);
    quiet = 1'b1;
    run_phase(150);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
